[rtl/core/voxel_center_of_mass_defines.svh]
// Assertion macros shared by the voxel centre-of-mass RTL.
// Depends on nothing; included by the controller and datapath modules.
`ifndef VOXEL_CENTER_OF_MASS_DEFINES_SVH
`define VOXEL_CENTER_OF_MASS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VCOM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VCOM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vcom_pkg.sv]
// Package for the voxel centre-of-mass block: widths, payload structs and
// the command and status types between controller and datapath. No dependencies.
package vcom_pkg;

  // Sizing of the coordinate grid and of the largest volume.
  localparam int COORD_BITS       = 8;
  localparam int VOXEL_COUNT_LOG2 = 24;

  // Field widths of the beats.
  localparam int DENS_W    = 32;
  localparam int POS_W     = 8;
  localparam int CENT_W    = 24;
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = CENT_W - FRAC_BITS;

  // Derived datapath widths.
  localparam int CRD_W  = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int MAG_W  = DENS_W - 1;
  localparam int PROD_W = MAG_W + CRD_W;
  localparam int MASS_W = DENS_W + VOXEL_COUNT_LOG2;
  localparam int WSUM_W = MASS_W + COORD_BITS;
  localparam int CMP_W  = WSUM_W + INT_BITS;
  localparam int CNT_W  = $clog2(CENT_W);

  typedef struct packed {
    logic signed [DENS_W-1:0] density;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_z;
    logic                     last_voxel;
  } voxel_in_t;

  typedef struct packed {
    logic [CENT_W-1:0] centroid_x;
    logic [CENT_W-1:0] centroid_y;
    logic [CENT_W-1:0] centroid_z;
    logic              empty_volume;
  } centroid_out_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  take;
    logic  div_load;
    logic  div_step;
    logic  div_store;
    logic  publish;
    axis_t axis;
  } vcom_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mass_zero;
    logic out_busy;
  } vcom_sts_t;

endpackage

[rtl/core/vcom_ctrl.sv]
// Controller of the voxel centre-of-mass block: sequences accumulation,
// the three shared divisions and the hand-over to the output register.
// Depends on vcom_pkg and voxel_center_of_mass_defines.svh.
`include "voxel_center_of_mass_defines.svh"

module vcom_ctrl
  import vcom_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  vcom_sts_t sts,
  output vcom_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_SETTLE,
    S_LOAD,
    S_ITER,
    S_STORE,
    S_PUBLISH
  } state_t;

  state_t             state_r, state_nxt;
  axis_t              axis_r, axis_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Commands are decoded from the current state.
  always_comb begin
    in_ready      = (state_r == S_ACCUM);
    cmd.take      = in_valid && (state_r == S_ACCUM);
    cmd.div_load  = (state_r == S_LOAD) && !sts.mass_zero;
    cmd.div_step  = (state_r == S_ITER);
    cmd.div_store = (state_r == S_STORE);
    cmd.publish   = (state_r == S_PUBLISH) && !sts.out_busy;
    cmd.axis      = axis_r;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_ACCUM: begin
        if (in_valid && in_last) begin
          state_nxt = S_SETTLE;
        end
      end
      S_SETTLE: begin
        state_nxt = S_LOAD;
        axis_nxt  = AXIS_X;
      end
      S_LOAD: begin
        cnt_nxt = '0;
        if (sts.mass_zero) begin
          state_nxt = S_PUBLISH;
        end else begin
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CENT_W - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        unique case (axis_r)
          AXIS_X: begin
            axis_nxt  = AXIS_Y;
            state_nxt = S_LOAD;
          end
          AXIS_Y: begin
            axis_nxt  = AXIS_Z;
            state_nxt = S_LOAD;
          end
          default: begin
            state_nxt = S_PUBLISH;
          end
        endcase
      end
      S_PUBLISH: begin
        if (!sts.out_busy) begin
          state_nxt = S_ACCUM;
        end
      end
      default: begin
        state_nxt = S_ACCUM;
      end
    endcase
  end

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
      axis_r  <= AXIS_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `VCOM_ASSERT_NXT(a_close_stops_intake, clk, rst_n, cmd.take && in_last, !in_ready, "voxel taken straight after the closing voxel")
  `VCOM_ASSERT_IMP(a_iter_count_bound, clk, rst_n, state_r == S_ITER, cnt_r < CNT_W'(CENT_W), "division step count ran past the quotient width")
  `VCOM_ASSERT_IMP(a_load_needs_mass, clk, rst_n, cmd.div_load, !sts.mass_zero, "division started with zero mass")

endmodule

[rtl/core/vcom_datapath.sv]
// Datapath of the voxel centre-of-mass block: product stage, mass and weighted
// accumulators, one shared restoring divider and the output register.
// Depends on vcom_pkg and voxel_center_of_mass_defines.svh.
`include "voxel_center_of_mass_defines.svh"

module vcom_datapath
  import vcom_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  voxel_in_t     in_data,
  input  vcom_cmd_t     cmd,
  input  logic          out_ready,
  output vcom_sts_t     sts,
  output logic          out_valid,
  output centroid_out_t out_data
);

  // Product stage.
  logic               p_vld_r;
  logic [MAG_W-1:0]   dens_r;
  logic [PROD_W-1:0]  prod_x_r, prod_y_r, prod_z_r;
  logic               dens_pos;
  logic [MAG_W-1:0]   dens_mag;

  // Accumulators.
  logic [MASS_W-1:0]  mass_r;
  logic [WSUM_W-1:0]  wsum_x_r, wsum_y_r, wsum_z_r;

  // Shared divider.
  logic [WSUM_W-1:0]  w_sel;
  logic [WSUM_W-1:0]  w_shr;
  logic               sat_nxt;
  logic               sat_r;
  logic [MASS_W-1:0]  rem_r, rem_nxt;
  logic [CENT_W-1:0]  sh_r;
  logic [CENT_W-1:0]  quo_r;
  logic [MASS_W:0]    trial;
  logic [MASS_W:0]    diff;
  logic               ge;

  // Per-axis results and output register.
  logic [CENT_W-1:0]  res_r [3];
  logic               out_valid_r;
  centroid_out_t      out_data_r;

  // Only strictly positive densities contribute.
  assign dens_pos = !in_data.density[DENS_W-1] && (|in_data.density);
  assign dens_mag = in_data.density[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.take && dens_pos;
    end
  end

  // Density times each coordinate, registered before accumulation.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dens_r   <= dens_mag;
      prod_x_r <= PROD_W'(dens_mag) * PROD_W'(in_data.pos_x[CRD_W-1:0]);
      prod_y_r <= PROD_W'(dens_mag) * PROD_W'(in_data.pos_y[CRD_W-1:0]);
      prod_z_r <= PROD_W'(dens_mag) * PROD_W'(in_data.pos_z[CRD_W-1:0]);
    end
  end

  // Accumulators wrap at their widths and clear once a result is published.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r   <= '0;
      wsum_x_r <= '0;
      wsum_y_r <= '0;
      wsum_z_r <= '0;
    end else if (cmd.publish) begin
      mass_r   <= '0;
      wsum_x_r <= '0;
      wsum_y_r <= '0;
      wsum_z_r <= '0;
    end else if (p_vld_r) begin
      mass_r   <= mass_r + MASS_W'(dens_r);
      wsum_x_r <= wsum_x_r + WSUM_W'(prod_x_r);
      wsum_y_r <= wsum_y_r + WSUM_W'(prod_y_r);
      wsum_z_r <= wsum_z_r + WSUM_W'(prod_z_r);
    end
  end

  // Pick the weighted sum for the axis being divided.
  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  w_sel = wsum_x_r;
      AXIS_Y:  w_sel = wsum_y_r;
      default: w_sel = wsum_z_r;
    endcase
  end

  // The quotient saturates when the integer part would not fit.
  assign w_shr   = w_sel >> INT_BITS;
  assign sat_nxt = CMP_W'(w_sel) >= (CMP_W'(mass_r) << INT_BITS);

  // One restoring step: shift in the next dividend bit and try a subtraction.
  assign trial   = {rem_r, sh_r[CENT_W-1]};
  assign diff    = trial - {1'b0, mass_r};
  assign ge      = trial >= {1'b0, mass_r};
  assign rem_nxt = ge ? diff[MASS_W-1:0] : trial[MASS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      sat_r <= sat_nxt;
      rem_r <= w_shr[MASS_W-1:0];
      sh_r  <= {w_sel[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_r << 1;
      quo_r <= {quo_r[CENT_W-2:0], ge};
    end
  end

  // Keep each finished quotient for its axis.
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.axis)
        AXIS_X:  res_r[0] <= sat_r ? {CENT_W{1'b1}} : quo_r;
        AXIS_Y:  res_r[1] <= sat_r ? {CENT_W{1'b1}} : quo_r;
        default: res_r[2] <= sat_r ? {CENT_W{1'b1}} : quo_r;
      endcase
    end
  end

  // Output register holds the beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (mass_r == '0) begin
        out_data_r.centroid_x   <= '0;
        out_data_r.centroid_y   <= '0;
        out_data_r.centroid_z   <= '0;
        out_data_r.empty_volume <= 1'b1;
      end else begin
        out_data_r.centroid_x   <= res_r[0];
        out_data_r.centroid_y   <= res_r[1];
        out_data_r.centroid_z   <= res_r[2];
        out_data_r.empty_volume <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.mass_zero = (mass_r == '0);
  assign sts.out_busy  = out_valid_r && !out_ready;

  `VCOM_ASSERT_IMP(a_rem_below_mass, clk, rst_n, cmd.div_step && !sat_r, rem_r < mass_r, "partial remainder not below the divisor")
  `VCOM_ASSERT_NXT(a_publish_clears, clk, rst_n, cmd.publish, mass_r == '0 && out_valid_r, "sums not cleared or result not shown after publish")

endmodule

[rtl/core/voxel_center_of_mass.sv]
// Voxel centre-of-mass block, top level: joins controller and datapath.
// Depends on vcom_pkg, vcom_ctrl and vcom_datapath.
//
// Usage: voxels arrive on the in_ channel (valid/ready, one voxel per beat)
// as a signed Q16.16 density with its x, y, z grid position. Voxels with a
// positive density are summed at one beat per clock; the products are
// registered before they reach the accumulators.
// The beat marked last_voxel closes the volume. The block then stops taking
// voxels and divides the three weighted sums by the mass on one shared
// restoring divider, one quotient bit per cycle: 24 steps plus the load and
// store states per axis. The centroid beat (Q8.16, truncated) is shown on the
// out_ channel once the third quotient is stored, or straight after the load
// state when no positive mass was seen (empty_volume set, centroids zero).
// Throughput is one voxel per cycle inside a volume; intake pauses once per
// volume for the divisions. While a result waits in the output register the
// next volume is accepted; only its own result publication waits for out_ready.
// Synchronous reset clears the sums and all control state; no beat is valid.
module voxel_center_of_mass
  import vcom_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  voxel_in_t     in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output centroid_out_t out_data
);

  vcom_cmd_t cmd;
  vcom_sts_t sts;

  vcom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_voxel),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vcom_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
